### design/crtst_pkg.sv
// ----------------------------------------------------------------------------
// crtst_pkg
// Shared types and constants for the CRT controller sync timing block:
// bus function codes, register indexes, write masks and reset values.
// ----------------------------------------------------------------------------
package crtst_pkg;

  // Register file geometry
  localparam int unsigned NumRegs    = 18;
  localparam int unsigned NumWrRegs  = 16;
  localparam int unsigned RegIdxW    = 4;

  // Register indexes used by the counting chain and the read path
  localparam logic [RegIdxW-1:0] RegHTotal    = 4'd0;
  localparam logic [RegIdxW-1:0] RegHSyncPos  = 4'd2;
  localparam logic [RegIdxW-1:0] RegSyncWidth = 4'd3;
  localparam logic [RegIdxW-1:0] RegVTotal    = 4'd4;
  localparam logic [RegIdxW-1:0] RegVSyncPos  = 4'd7;
  localparam logic [RegIdxW-1:0] RegMaxLine   = 4'd9;
  localparam logic [RegIdxW-1:0] RegCursorHi  = 4'd14;
  localparam logic [RegIdxW-1:0] RegCursorLo  = 4'd15;

  // First readable register and first address beyond the file
  localparam logic [7:0] RegFirstRead = 8'd14;
  localparam logic [7:0] RegLimit     = 8'd18;

  // Bus function carried with each item
  typedef enum logic [2:0] {
    FUNC_TICK    = 3'd0,
    FUNC_WR_ADDR = 3'd1,
    FUNC_RD_ADDR = 3'd2,
    FUNC_WR_DATA = 3'd3,
    FUNC_RD_DATA = 3'd4
  } func_e;

  typedef logic [7:0] byte_t;

  // Per-register write masks, R0..R17
  localparam byte_t REG_MASK [NumRegs] = '{
    8'hff, 8'hff, 8'hff, 8'h0f, 8'h7f, 8'h1f, 8'h7f, 8'h7f, 8'h03,
    8'h1f, 8'h7f, 8'h1f, 8'h3f, 8'hff, 8'h3f, 8'hff, 8'h3f, 8'hff
  };

  // Reset values of the writable registers R0..R15
  localparam byte_t REG_RESET [NumWrRegs] = '{
    8'h3f, 8'h28, 8'h2e, 8'h0e, 8'h26, 8'h00, 8'h19, 8'h1e,
    8'h00, 8'h07, 8'h00, 8'h00, 8'h30, 8'h00, 8'h00, 8'h00
  };

endpackage

### design/crt_controller_sync_timing.sv
// ----------------------------------------------------------------------------
// crt_controller_sync_timing
// 6845-style register file and character/scanline/row counting chain with
// horizontal and vertical sync generation, one tick or bus access per item.
// ----------------------------------------------------------------------------
//
//  channel   dir  data                                        user / last
//  s_axis    in   tdata[7:0] bus_data                         tuser[2:0] func
//  m_axis    out  tdata[7:0] bus_out, [8] hsync_level,        tlast frame_end
//                 [9] vsync_level, [10] hsync_edge,
//                 [11] vsync_edge, [15:12] zero
//
//  One item per clock. The whole tick or access is evaluated in the cycle
//  the item is accepted; state updates at that edge and the result lands in
//  the output register, visible on m_axis in the following cycle.
//  The input side is ready whenever the output register is empty or is
//  being drained, so a stall on m_axis holds one result and back-pressures.
//  rst_ni clears counters, sync state and the address register and loads
//  the register file with its reset values.
// ----------------------------------------------------------------------------
module crt_controller_sync_timing
  import crtst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: [7:0] bus_data
  input  logic [7:0]  s_axis_tdata,
  // tuser: [2:0] func
  input  logic [2:0]  s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: [7:0] bus_out, [8] hsync_level, [9] vsync_level,
  //        [10] hsync_edge, [11] vsync_edge, [15:12] zero
  output logic [15:0] m_axis_tdata,
  // tlast: frame_end
  output logic        m_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready
);

  // State
  byte_t       sel_q, sel_d;
  byte_t       regs_q [NumWrRegs];
  byte_t       hcc_q, hcc_d;
  byte_t       slc_q, slc_d;
  byte_t       row_q, row_d;
  logic [3:0]  hsc_q, hsc_d;
  logic [3:0]  vsc_q, vsc_d;
  logic        hact_q, hact_d;
  logic        vact_q, vact_d;

  // Output register
  logic        out_vld_q;
  logic [15:0] out_data_q, out_data_d;
  logic        out_last_q, out_last_d;

  logic        in_acc;
  logic        reg_we;
  func_e       func;
  byte_t       bus;

  // Counting chain intermediates
  byte_t       hcc_inc, slc_inc, row_inc;
  logic [3:0]  hsc_inc, vsc_inc;
  logic        line_step, row_step, frame;
  byte_t       rd_val, result;

  assign func = func_e'(s_axis_tuser);
  assign bus  = s_axis_tdata;

  // Input taken whenever the output register can take the result
  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Tick: character -> scanline -> row, with sync width counters
  always_comb begin
    hcc_d     = hcc_q;
    slc_d     = slc_q;
    row_d     = row_q;
    hsc_d     = hsc_q;
    vsc_d     = vsc_q;
    hact_d    = hact_q;
    vact_d    = vact_q;
    line_step = 1'b0;
    row_step  = 1'b0;
    frame     = 1'b0;
    hcc_inc   = hcc_q + 8'd1;
    slc_inc   = slc_q + 8'd1;
    row_inc   = row_q + 8'd1;
    hsc_inc   = hsc_q + 4'd1;
    vsc_inc   = vsc_q + 4'd1;

    if (func == FUNC_TICK) begin
      // character counter
      line_step = (hcc_inc == byte_t'(regs_q[RegHTotal] + 8'd1));
      hcc_d     = line_step ? 8'd0 : hcc_inc;

      // hsync: width count while active, start at programmed position
      if (hact_q) begin
        if (hsc_inc == regs_q[RegSyncWidth][3:0]) begin
          hsc_d  = 4'd0;
          hact_d = 1'b0;
        end else begin
          hsc_d  = hsc_inc;
        end
      end else if (hcc_d == regs_q[RegHSyncPos]) begin
        hsc_d  = 4'd0;
        hact_d = 1'b1;
      end

      // scanline step and vsync
      if (line_step) begin
        row_step = (slc_inc == byte_t'(regs_q[RegMaxLine] + 8'd1));
        slc_d    = row_step ? 8'd0 : slc_inc;
        if (vact_q) begin
          if (vsc_inc == regs_q[RegSyncWidth][7:4]) begin
            vsc_d  = 4'd0;
            vact_d = 1'b0;
          end else begin
            vsc_d  = vsc_inc;
          end
        end else if (row_q == regs_q[RegVSyncPos]) begin
          vsc_d  = 4'd0;
          vact_d = 1'b1;
        end
      end

      // row step and frame end
      if (row_step) begin
        frame = (row_inc == byte_t'(regs_q[RegVTotal] + 8'd1));
        row_d = frame ? 8'd0 : row_inc;
      end
    end
  end

  // Read path: only R14..R17 answer; R16/R17 are never written and read 0
  always_comb begin
    if (sel_q >= RegLimit - 8'd2) begin
      rd_val = 8'd0;
    end else if (sel_q[0]) begin
      rd_val = regs_q[RegCursorLo] & REG_MASK[{1'b0, RegCursorLo}];
    end else begin
      rd_val = regs_q[RegCursorHi] & REG_MASK[{1'b0, RegCursorHi}];
    end
  end

  // Bus result and address register
  assign reg_we = (func == FUNC_WR_DATA) && (sel_q[7:RegIdxW] == '0);

  always_comb begin
    result = bus;
    sel_d  = sel_q;
    case (func)
      FUNC_WR_ADDR: sel_d = bus;
      FUNC_WR_DATA: begin
        if (reg_we) begin
          result = bus & REG_MASK[{1'b0, sel_q[RegIdxW-1:0]}];
        end
      end
      FUNC_RD_DATA: begin
        if (sel_q >= RegFirstRead && sel_q < RegLimit) begin
          result = rd_val;
        end
      end
      default: result = bus;
    endcase
  end

  assign out_data_d = {4'd0, (vact_d != vact_q), (hact_d != hact_q),
                       vact_d, hact_d, result};
  assign out_last_d = frame;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q  <= '0;
      hcc_q  <= '0;
      slc_q  <= '0;
      row_q  <= '0;
      hsc_q  <= '0;
      vsc_q  <= '0;
      hact_q <= 1'b0;
      vact_q <= 1'b0;
    end else if (in_acc) begin
      sel_q  <= sel_d;
      hcc_q  <= hcc_d;
      slc_q  <= slc_d;
      row_q  <= row_d;
      hsc_q  <= hsc_d;
      vsc_q  <= vsc_d;
      hact_q <= hact_d;
      vact_q <= vact_d;
    end
  end

  // Register file R0..R15, loaded with programmed defaults at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumWrRegs; i++) begin
        regs_q[i] <= REG_RESET[i];
      end
    end else if (in_acc && reg_we) begin
      regs_q[sel_q[RegIdxW-1:0]] <= bus & REG_MASK[{1'b0, sel_q[RegIdxW-1:0]}];
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (in_acc) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= out_data_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

### design/crtst_checker.sv
// ----------------------------------------------------------------------------
// crtst_checker
// Port-level checks for the CRT controller sync timing block, bound to the
// top level.
// ----------------------------------------------------------------------------
module crtst_checker
  import crtst_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic [7:0]  s_axis_tdata,
  input logic [2:0]  s_axis_tuser,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready
);

  logic in_acc;
  logic is_tick;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign is_tick = (s_axis_tuser == FUNC_TICK);

  // An empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  // Every accepted item shows up on the next cycle
  a_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> m_axis_tvalid)
    else $error("result missing one cycle after accept");

  // Bus accesses report no edges and no frame end
  a_access_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !is_tick) |=> (!m_axis_tdata[10] && !m_axis_tdata[11]
                              && !m_axis_tlast))
    else $error("edge or frame flag on a bus access");

  // A tick passes the bus byte through
  a_tick_bus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_tick) |=> (m_axis_tdata[7:0] == $past(s_axis_tdata)))
    else $error("tick did not pass bus byte through");

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled result changed");

endmodule

bind crt_controller_sync_timing crtst_checker u_crtst_checker (.*);

### bench/crt_controller_sync_timing_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_controller_sync_timing_tb
// Self-checking bench for the CRT sync timing block. Bus accesses and
// character ticks go in on the input stream while an in-bench model of the
// register file and the character/scanline/row chain predicts each result.
// Every output item is compared field by field under several idle patterns.
// ----------------------------------------------------------------------------
module crt_controller_sync_timing_tb;
  import crtst_pkg::*;

  // Function codes the block does not decode
  localparam logic [2:0] FuncFirstUnknown = 3'd5;
  localparam logic [2:0] FuncLastCode     = 3'd7;
  // Read-only light pen registers
  localparam logic [7:0] RegLightPenHi = 8'd16;
  localparam logic [7:0] RegLightPenLo = 8'd17;
  localparam int unsigned MaxPrinted   = 40;
  localparam int unsigned PhaseItems   = 300;

  typedef struct packed {
    byte_t bus_out;
    logic  hs_level;
    logic  vs_level;
    logic  hs_edge;
    logic  vs_edge;
    logic  frame_end;
  } crtc_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic [7:0]  s_axis_tdata  = '0;
  logic [2:0]  s_axis_tuser  = FUNC_TICK;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;

  int unsigned send_idle_pct   = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned items_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches      = 0;
  crtc_result_t pending_results [$];

  // Predicted block state
  byte_t      sel_reg;
  byte_t      crtc_regs [NumRegs];
  byte_t      h_count;
  byte_t      line_count;
  byte_t      row_count;
  logic [3:0] hs_width_count;
  logic [3:0] vs_width_count;
  logic       hs_on;
  logic       vs_on;

  crt_controller_sync_timing i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Receiver stalls at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic model_reset();
    sel_reg = '0;
    for (int i = 0; i < NumRegs; i++) begin
      crtc_regs[i] = (i < NumWrRegs) ? REG_RESET[i] : '0;
    end
    h_count        = '0;
    line_count     = '0;
    row_count      = '0;
    hs_width_count = '0;
    vs_width_count = '0;
    hs_on          = 1'b0;
    vs_on          = 1'b0;
  endtask

  // Applies one item to the predicted state and returns the expected result
  function automatic crtc_result_t crtc_predict(input logic [2:0] fn, input byte_t data);
    crtc_result_t res;
    logic  h_was;
    logic  v_was;
    logic  line_step;
    logic  row_step;
    byte_t h_total;
    byte_t l_total;
    byte_t r_total;
    h_was     = hs_on;
    v_was     = vs_on;
    line_step = 1'b0;
    row_step  = 1'b0;
    h_total   = crtc_regs[{1'b0, RegHTotal}] + 8'd1;
    l_total   = crtc_regs[{1'b0, RegMaxLine}] + 8'd1;
    r_total   = crtc_regs[{1'b0, RegVTotal}] + 8'd1;
    res       = '0;
    res.bus_out = data;
    case (fn)
      FUNC_TICK: begin
        // character counter and hsync
        h_count = h_count + 8'd1;
        if (h_count == h_total) begin
          h_count   = '0;
          line_step = 1'b1;
        end
        if (h_was) begin
          hs_width_count = hs_width_count + 4'd1;
          if (hs_width_count == crtc_regs[{1'b0, RegSyncWidth}][3:0]) begin
            hs_width_count = '0;
            hs_on          = 1'b0;
          end
        end else if (h_count == crtc_regs[{1'b0, RegHSyncPos}]) begin
          hs_width_count = '0;
          hs_on          = 1'b1;
        end
        // scanline counter and vsync, row compare uses the old row
        if (line_step) begin
          line_count = line_count + 8'd1;
          if (line_count == l_total) begin
            line_count = '0;
            row_step   = 1'b1;
          end
          if (v_was) begin
            vs_width_count = vs_width_count + 4'd1;
            if (vs_width_count == crtc_regs[{1'b0, RegSyncWidth}][7:4]) begin
              vs_width_count = '0;
              vs_on          = 1'b0;
            end
          end else if (row_count == crtc_regs[{1'b0, RegVSyncPos}]) begin
            vs_width_count = '0;
            vs_on          = 1'b1;
          end
        end
        if (row_step) begin
          row_count = row_count + 8'd1;
          if (row_count == r_total) begin
            row_count     = '0;
            res.frame_end = 1'b1;
          end
        end
        res.hs_edge = hs_on ^ h_was;
        res.vs_edge = vs_on ^ v_was;
      end
      FUNC_WR_ADDR: sel_reg = data;
      FUNC_WR_DATA: begin
        if (sel_reg < NumWrRegs) begin
          crtc_regs[sel_reg[4:0]] = data & REG_MASK[sel_reg[4:0]];
          res.bus_out             = crtc_regs[sel_reg[4:0]];
        end
      end
      FUNC_RD_DATA: begin
        if (sel_reg >= RegFirstRead && sel_reg < RegLimit) begin
          res.bus_out = crtc_regs[sel_reg[4:0]] & REG_MASK[sel_reg[4:0]];
        end
      end
      default: ;
    endcase
    res.hs_level = hs_on;
    res.vs_level = vs_on;
    return res;
  endfunction

  // Sends one item; called and returns at a rising edge
  task automatic send_item(input logic [2:0] fn, input byte_t data);
    logic ready_seen;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= data;
    do begin
      @(negedge clk_i);
      ready_seen = s_axis_tready;
      @(posedge clk_i);
    end while (!ready_seen);
    pending_results.push_back(crtc_predict(fn, data));
    items_sent++;
  endtask

  task automatic write_reg(input byte_t idx, input byte_t value);
    send_item(FUNC_WR_ADDR, idx);
    send_item(FUNC_WR_DATA, value);
  endtask

  // Sender holds off until every predicted result has come out
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= MaxPrinted) begin
      $display("[%0t] result %0d: %s got 0x%0h, want 0x%0h",
               $realtime, results_checked, what, got, want);
    end
  endtask

  // Result checker, sampled mid-cycle where the handshake is stable
  always @(negedge clk_i) begin : result_check
    crtc_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, 0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[7:0] !== want.bus_out)
          report_mismatch("bus_out", m_axis_tdata[7:0], want.bus_out);
        if (m_axis_tdata[8] !== want.hs_level)
          report_mismatch("hsync_level", m_axis_tdata[8], want.hs_level);
        if (m_axis_tdata[9] !== want.vs_level)
          report_mismatch("vsync_level", m_axis_tdata[9], want.vs_level);
        if (m_axis_tdata[10] !== want.hs_edge)
          report_mismatch("hsync_edge", m_axis_tdata[10], want.hs_edge);
        if (m_axis_tdata[11] !== want.vs_edge)
          report_mismatch("vsync_edge", m_axis_tdata[11], want.vs_edge);
        if (m_axis_tdata[15:12] !== 4'h0)
          report_mismatch("tdata padding", m_axis_tdata[15:12], 0);
        if (m_axis_tlast !== want.frame_end)
          report_mismatch("frame_end", m_axis_tlast, want.frame_end);
      end
      results_checked++;
    end
  end

  // Directed bus accesses: masks, read permissions, odd selections
  task automatic test_bus_access();
    for (int f = FuncFirstUnknown; f <= FuncLastCode; f++) begin
      send_item(3'(f), (f % 2 != 0) ? 8'hff : 8'h00);
    end
    send_item(FUNC_RD_ADDR, 8'h5a);
    // cursor high: writable, readable, 6-bit mask
    write_reg(byte_t'(RegCursorHi), 8'hff);
    send_item(FUNC_RD_DATA, 8'h00);
    // light pen registers ignore writes
    write_reg(RegLightPenHi, 8'hff);
    send_item(FUNC_RD_DATA, 8'h00);
    send_item(FUNC_WR_ADDR, RegLightPenLo);
    send_item(FUNC_RD_DATA, 8'hff);
    // sync widths of zero (16 steps); register is write-only
    write_reg(byte_t'(RegSyncWidth), 8'hf0);
    send_item(FUNC_RD_DATA, 8'ha5);
    // selections past the end of the file
    write_reg(RegLimit, 8'h12);
    send_item(FUNC_RD_DATA, 8'h34);
    send_item(FUNC_WR_ADDR, 8'hff);
    send_item(FUNC_RD_DATA, 8'hc3);
    repeat (4) send_item(FUNC_TICK, byte_t'($urandom));
  endtask

  // Program a small raster, then run ticks with some noise mixed in
  task automatic run_timing_sequence();
    byte_t       h_total;
    byte_t       l_total;
    byte_t       r_total;
    bit          overrun;
    int unsigned n_ticks;
    // overrun: total dropped below the running count, counter wraps at 255
    overrun = ($urandom_range(7) == 0) && (h_count != 0);
    if (overrun) begin
      h_total = byte_t'($urandom_range(h_count - 1));
    end else begin
      h_total = ($urandom_range(15) == 0) ? byte_t'($urandom_range(255, 40))
                                          : byte_t'($urandom_range(12));
      if (h_total < h_count) h_total = h_count;
    end
    l_total = byte_t'($urandom_range(3));
    if (l_total < line_count) l_total = line_count;
    r_total = byte_t'($urandom_range(3));
    if (r_total < row_count) r_total = row_count;
    write_reg(byte_t'(RegHTotal), h_total);
    write_reg(byte_t'(RegMaxLine), l_total);
    write_reg(byte_t'(RegVTotal), r_total);
    if ($urandom_range(3) != 0) begin
      write_reg(byte_t'(RegHSyncPos), ($urandom_range(7) == 0) ? byte_t'($urandom)
                                                : byte_t'($urandom_range(14)));
    end
    if ($urandom_range(3) != 0) write_reg(byte_t'(RegSyncWidth), byte_t'($urandom));
    if ($urandom_range(3) != 0) begin
      write_reg(byte_t'(RegVSyncPos), byte_t'($urandom_range(r_total + 1)));
    end
    n_ticks = overrun ? 300 : $urandom_range(150, 30);
    repeat (n_ticks) begin
      if ($urandom_range(19) == 0) send_item(3'($urandom_range(7)), byte_t'($urandom));
      else send_item(FUNC_TICK, byte_t'($urandom));
    end
  endtask

  // Random register accesses, some without a preceding select
  task automatic run_register_sequence();
    byte_t       addr;
    int unsigned n_acc;
    addr = ($urandom_range(3) == 0) ? byte_t'($urandom)
                                    : byte_t'($urandom_range(RegLimit + 1));
    if ($urandom_range(5) != 0) send_item(FUNC_WR_ADDR, addr);
    n_acc = $urandom_range(3, 1);
    repeat (n_acc) begin
      case ($urandom_range(5))
        0, 1:    send_item(FUNC_WR_DATA, byte_t'($urandom));
        2, 3:    send_item(FUNC_RD_DATA, byte_t'($urandom));
        4:       send_item(FUNC_RD_ADDR, byte_t'($urandom));
        default: send_item(3'($urandom_range(FuncLastCode, FuncFirstUnknown)),
                           byte_t'($urandom));
      endcase
    end
  endtask

  // Sync timing under one idle pattern, then wait for all results
  task automatic test_sync_timing(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned stop_at;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at        = items_sent + PhaseItems;
    while (items_sent < stop_at) begin
      if ($urandom_range(9) < 7) run_timing_sequence();
      else run_register_sequence();
    end
    drain_results();
  endtask

  initial begin
    model_reset();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_bus_access();
    drain_results();
    test_sync_timing(0, 0);
    test_sync_timing(65, 0);
    test_sync_timing(0, 65);
    test_sync_timing(17, 17);
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
